### rtl/rpt_pkg.sv
// Shared types and codes for the retransmit pending table.
// Request, result and table entry structs, request and status codes, interval reset value, sequencer states.
// No dependencies.
package rpt_pkg;

	// Request codes carried in req_type
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_SCAN   = 2'd2;
	localparam logic [1:0] REQ_LOOKUP = 2'd3;

	// Result status codes
	localparam logic [2:0] ST_INSERTED = 3'd0;
	localparam logic [2:0] ST_FULL     = 3'd1;
	localparam logic [2:0] ST_DELETED  = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_RESEND   = 3'd4;
	localparam logic [2:0] ST_DONE     = 3'd5;
	localparam logic [2:0] ST_EMPTY    = 3'd6;
	localparam logic [2:0] ST_FOUND    = 3'd7;

	// Reset value of the retransmit interval register
	localparam logic [31:0] INTERVAL_RST = 32'd1000;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  msg_id;
		logic [63:0] addr_high;
		logic [63:0] addr_low;
		logic [7:0]  pkt_handle;
		logic [31:0] time_now;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_msg_id;
		logic [63:0] out_addr_high;
		logic [63:0] out_addr_low;
		logic [7:0]  out_handle;
		logic        last;
	} res_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [63:0] addr_hi;
		logic [63:0] addr_lo;
		logic [7:0]  handle;
		logic [31:0] sent_time;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_CLOSE
	} state_t;

endpackage

### rtl/rpt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Used for the entry store of the retransmit pending table. No dependencies.
module rpt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/retransmit_pending_table.sv
// Retransmit pending table: top level with the request sequencer.
// Depends on rpt_pkg (types and codes) and rpt_ram (entry store).
//
// The table keeps up to TABLE_ENTRIES unacknowledged messages, newest first, in a
// single RAM with one read and one write port. A request is transferred when start
// is high and busy is low. Results come out on res for one cycle each, marked by
// res_valid; the receiver cannot stall them, so take every result as it appears.
// res.last marks the final result of a request. Insert into a full table and scan
// of an empty table answer in the next cycle and leave busy low. Insert, delete and
// lookup on an empty table skip the walk and go straight to the close state. Every
// other request walks the RAM one entry per cycle through its read port: insert,
// delete, scan and a missed lookup walk every entry, while a lookup that hits an
// entry ends the walk there. A scan puts out its resend results while walking
// and closes with the done result. Insert shifts entries toward the tail, delete
// shifts them toward the head, both with read and write-back in the same pass. The
// interval register may be written at any time busy is low; cfg_ready is always
// high.
module retransmit_pending_table #(
	parameter int TABLE_ENTRIES = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rpt_pkg::req_t req,
	output logic          res_valid,
	output rpt_pkg::res_t res,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [31:0]   cfg_data
);
	import rpt_pkg::*;

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(TABLE_ENTRIES);
	localparam int ENT_W = $bits(entry_t);

	// Sequencer state and control
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;     // entries in the table
	logic [CNT_W-1:0] iss_q, iss_d;     // reads issued in this walk
	logic [IDX_W-1:0] ptr_q, ptr_d;     // next read address
	logic             pend_q, pend_d;   // read data valid this cycle
	logic             shift_q, shift_d; // delete has matched, now closing the gap
	logic [31:0]      interval_q;

	// Payload
	req_t             req_q, req_d;
	logic [IDX_W-1:0] pidx_q, pidx_d;   // address of the data on rd_ent
	res_t             res_q, res_d;
	logic             res_valid_q, res_valid_d;

	// RAM port signals
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic [ENT_W-1:0] rd_raw;
	entry_t           rd_ent;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	entry_t           wr_data;

	// Shared compare and elapsed-time unit, applied to one entry per cycle
	logic [31:0]      elapsed;
	logic             id_hit;
	logic             addr_hit;

	function automatic res_t mk_res(logic [2:0] st, logic [7:0] id, logic [63:0] hi,
			logic [63:0] lo, logic [7:0] h, logic fin);
		res_t r;
		r.status        = st;
		r.out_msg_id    = id;
		r.out_addr_high = hi;
		r.out_addr_low  = lo;
		r.out_handle    = h;
		r.last          = fin;
		return r;
	endfunction

	rpt_ram #(
		.WIDTH(ENT_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	assign rd_ent   = entry_t'(rd_raw);
	assign elapsed  = req_q.time_now - rd_ent.sent_time;
	assign id_hit   = (rd_ent.id == req_q.msg_id);
	assign addr_hit = id_hit && (rd_ent.addr_hi == req_q.addr_high)
		&& (rd_ent.addr_lo == req_q.addr_low);

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		iss_d       = iss_q;
		ptr_d       = ptr_q;
		pend_d      = 1'b0;
		shift_d     = shift_q;
		req_d       = req_q;
		pidx_d      = pidx_q;
		res_d       = res_q;
		res_valid_d = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = ptr_q;
		wr_en       = 1'b0;
		wr_addr     = pidx_q;
		wr_data     = rd_ent;

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					req_d   = req;
					iss_d   = '0;
					shift_d = 1'b0;
					// insert walks from the tail down, everything else from the head up
					if (req.req_type == REQ_INSERT) begin
						ptr_d = IDX_W'(cnt_q - CNT_W'(1));
					end else begin
						ptr_d = '0;
					end
					priority if (req.req_type == REQ_INSERT && cnt_q == CNT_FULL) begin
						res_valid_d = 1'b1;
						res_d = mk_res(ST_FULL, req.msg_id, req.addr_high, req.addr_low,
							req.pkt_handle, 1'b1);
					end else if (req.req_type == REQ_SCAN && cnt_q == '0) begin
						res_valid_d = 1'b1;
						res_d = mk_res(ST_EMPTY, 8'd0, 64'd0, 64'd0, 8'd0, 1'b1);
					end else if (cnt_q == '0) begin
						state_d = S_CLOSE;
					end else begin
						state_d = S_WALK;
					end
				end
			end

			S_WALK: begin
				// issue the next read while entries remain
				if (iss_q != cnt_q) begin
					rd_en  = 1'b1;
					pend_d = 1'b1;
					pidx_d = ptr_q;
					iss_d  = CNT_W'(iss_q + CNT_W'(1));
					if (req_q.req_type == REQ_INSERT) begin
						ptr_d = IDX_W'(ptr_q - IDX_W'(1));
					end else begin
						ptr_d = IDX_W'(ptr_q + IDX_W'(1));
					end
				end
				// evaluate the entry read last cycle
				if (pend_q) begin
					if (iss_q == cnt_q) begin
						state_d = S_CLOSE;
					end
					unique case (req_q.req_type)
						REQ_INSERT: begin
							wr_en   = 1'b1;
							wr_addr = IDX_W'(pidx_q + IDX_W'(1));
						end
						REQ_DELETE: begin
							if (shift_q) begin
								wr_en   = 1'b1;
								wr_addr = IDX_W'(pidx_q - IDX_W'(1));
							end else if (addr_hit) begin
								shift_d     = 1'b1;
								res_valid_d = 1'b1;
								res_d = mk_res(ST_DELETED, rd_ent.id, rd_ent.addr_hi,
									rd_ent.addr_lo, rd_ent.handle, 1'b1);
							end
						end
						REQ_SCAN: begin
							if (elapsed > interval_q) begin
								wr_en             = 1'b1;
								wr_data.sent_time = req_q.time_now;
								res_valid_d       = 1'b1;
								res_d = mk_res(ST_RESEND, rd_ent.id, rd_ent.addr_hi,
									rd_ent.addr_lo, rd_ent.handle, 1'b0);
							end
						end
						REQ_LOOKUP: begin
							if (id_hit) begin
								// drop the read still in flight
								state_d     = S_IDLE;
								res_valid_d = 1'b1;
								res_d = mk_res(ST_FOUND, rd_ent.id, rd_ent.addr_hi,
									rd_ent.addr_lo, rd_ent.handle, 1'b1);
							end
						end
						default: ;
					endcase
				end
			end

			S_CLOSE: begin
				state_d = S_IDLE;
				unique case (req_q.req_type)
					REQ_INSERT: begin
						wr_en             = 1'b1;
						wr_addr           = '0;
						wr_data.id        = req_q.msg_id;
						wr_data.addr_hi   = req_q.addr_high;
						wr_data.addr_lo   = req_q.addr_low;
						wr_data.handle    = req_q.pkt_handle;
						wr_data.sent_time = req_q.time_now;
						cnt_d             = CNT_W'(cnt_q + CNT_W'(1));
						res_valid_d       = 1'b1;
						res_d = mk_res(ST_INSERTED, req_q.msg_id, req_q.addr_high,
							req_q.addr_low, req_q.pkt_handle, 1'b1);
					end
					REQ_DELETE: begin
						if (shift_q) begin
							cnt_d = CNT_W'(cnt_q - CNT_W'(1));
						end else begin
							res_valid_d = 1'b1;
							res_d = mk_res(ST_NOTFOUND, req_q.msg_id, req_q.addr_high,
								req_q.addr_low, 8'd0, 1'b1);
						end
					end
					REQ_SCAN: begin
						res_valid_d = 1'b1;
						res_d = mk_res(ST_DONE, 8'd0, 64'd0, 64'd0, 8'd0, 1'b1);
					end
					REQ_LOOKUP: begin
						res_valid_d = 1'b1;
						res_d = mk_res(ST_NOTFOUND, req_q.msg_id, 64'd0, 64'd0, 8'd0, 1'b1);
					end
					default: ;
				endcase
			end

			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			iss_q       <= '0;
			ptr_q       <= '0;
			pend_q      <= 1'b0;
			shift_q     <= 1'b0;
			res_valid_q <= 1'b0;
			interval_q  <= INTERVAL_RST;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			iss_q       <= iss_d;
			ptr_q       <= ptr_d;
			pend_q      <= pend_d;
			shift_q     <= shift_d;
			res_valid_q <= res_valid_d;
			if (cfg_valid && cfg_ready) begin
				interval_q <= cfg_data;
			end
		end
	end

	// Hold request, read index and result payload; no reset needed
	always_ff @(posedge clk) begin
		req_q  <= req_d;
		pidx_q <= pidx_d;
		res_q  <= res_d;
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;
	assign cfg_ready = 1'b1;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("entry count above table size");

	a_iss_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (iss_q <= cnt_q))
		else $error("walk issued more reads than entries");

	a_wr_src: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_CLOSE) || pend_q)
		else $error("RAM write without evaluated entry");

	a_ins_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLOSE && req_q.req_type == REQ_INSERT) |-> (cnt_q != CNT_FULL))
		else $error("insert closing on a full table");

	a_resend_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.status == ST_RESEND) |-> (!res.last && busy))
		else $error("resend result not followed by scan close");

endmodule
